// ===== src/ptdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdt_pkg
// Shared types and constants for the per-thread duty throttle router.
// ----------------------------------------------------------------------------
`default_nettype none

package ptdt_pkg;

    // Request kinds carried in s_axis_tuser
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_SET = 1'b1;

    // Result queue codes carried in m_axis_tuser
    localparam logic QUEUE_NORMAL = 1'b0;
    localparam logic QUEUE_SLOW   = 1'b1;

    // Field widths
    localparam int SLOT_W  = 12;
    localparam int LEVEL_W = 32;
    localparam int FLAGS_W = 64;
    localparam int VAL_W   = 7;

    // Stream data widths, padded to whole bytes
    localparam int S_DATA_W = ((SLOT_W + LEVEL_W + FLAGS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SLOT_W + FLAGS_W + 7) / 8) * 8;

    // Saturation level and duty period
    localparam logic [VAL_W-1:0] LEVEL_CAP   = 7'd100;
    localparam logic [VAL_W:0]   DUTY_PERIOD = 8'd100;

    // One table entry: duty remainder over throttle level
    typedef struct packed {
        logic [VAL_W-1:0] rem;
        logic [VAL_W-1:0] lvl;
    } duty_word_t;

    localparam int WORD_W = $bits(duty_word_t);

    // Update decision for one request
    typedef struct packed {
        logic we;
        logic target;
    } upd_res_t;

endpackage

`default_nettype wire

// ===== src/ptdt_ram.sv =====
// ----------------------------------------------------------------------------
// ptdt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ptdt_clr.sv =====
// ----------------------------------------------------------------------------
// ptdt_clr
// Clearing sequencer: after reset, sweeps the table writing zero entries,
// one address per cycle, and flags busy until the sweep is done.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdt_clr #(
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    output logic                          busy,
    output logic      [$clog2(DEPTH)-1:0] addr
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;

    // Advance the sweep, stop at the last entry
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_ADDR) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy = busy_reg;
    assign addr = cnt_reg;

endmodule

`default_nettype wire

// ===== src/ptdt_update.sv =====
// ----------------------------------------------------------------------------
// ptdt_update
// Modify step of the table read-modify-write: stores a new level, or adds the
// level to the duty remainder modulo 100 and picks the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdt_update
    import ptdt_pkg::*;
(
    input  wire duty_word_t       cur_word,
    input  wire logic             mode,
    input  wire logic [VAL_W-1:0] lvl_sat,
    input  wire logic             active,
    input  wire logic             in_table,
    output duty_word_t            new_word,
    output upd_res_t              res
);

    logic [VAL_W:0] sum;
    logic           wrap;

    // Add level to remainder, fold back below the period
    assign sum  = {1'b0, cur_word.rem} + {1'b0, cur_word.lvl};
    assign wrap = (sum >= DUTY_PERIOD);

    always_comb begin
        new_word   = cur_word;
        res.we     = 1'b0;
        res.target = QUEUE_NORMAL;
        case (mode)
            MODE_SET: begin
                new_word.lvl = lvl_sat;
                res.we       = in_table;
            end
            MODE_ENQ: begin
                if (in_table && active && (cur_word.lvl != '0)) begin
                    res.we       = 1'b1;
                    new_word.rem = wrap ? VAL_W'(sum - DUTY_PERIOD) : sum[VAL_W-1:0];
                    res.target   = wrap ? QUEUE_SLOW : QUEUE_NORMAL;
                end
            end
            default: begin
                res.we = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/per_thread_duty_throttle_router.sv =====
// ----------------------------------------------------------------------------
// per_thread_duty_throttle_router
// Routes enqueue requests to the normal or the slow queue from a per-thread
// throttle level and duty remainder held in one table memory.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake                      Contents
//  s_axis    in    s_axis_tvalid/s_axis_tready    tuser: mode; tdata: slot, level, flags
//  m_axis    out   m_axis_tvalid/m_axis_tready    tuser: target queue; tdata: slot, flags
//  cfg       in    cfg_we                         cfg_wdata: throttling_active
//
//  One request per cycle while s_axis_tready is high. An item reads its table
//  entry when it is accepted and writes it back from the update stage once that
//  stage advances; a repeated slot takes the value just written from a bypass
//  register. A result passes the update stage and then the output register. After
//  reset the table is cleared with s_axis_tready low. A stalled m_axis holds one
//  result and one more request in flight before s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module per_thread_duty_throttle_router
    import ptdt_pkg::*;
#(
    parameter int THREAD_SLOTS = 4096
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Configuration
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,     // throttling_active
    // Request stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // thread_slot, level, enqueue_flags
    input  wire logic                s_axis_tuser,  // mode
    // Result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [M_DATA_W-1:0] m_axis_tdata,  // routed_thread, flags_out
    output logic                     m_axis_tuser   // target_queue
);

    localparam int ADDR_W = $clog2(THREAD_SLOTS);
    localparam int CMP_W  = (ADDR_W + 1 > SLOT_W + 1) ? ADDR_W + 1 : SLOT_W + 1;
    localparam logic [CMP_W-1:0] SLOTS_LIM = CMP_W'(THREAD_SLOTS);

    // Input field unpacking
    logic [SLOT_W-1:0]  in_slot;
    logic [LEVEL_W-1:0] in_level;
    logic [FLAGS_W-1:0] in_flags;
    logic [CMP_W-1:0]   in_slot_ext;
    logic [VAL_W-1:0]   in_lvl_sat;
    logic               in_fire;

    assign in_slot     = s_axis_tdata[SLOT_W-1:0];
    assign in_level    = s_axis_tdata[SLOT_W +: LEVEL_W];
    assign in_flags    = s_axis_tdata[SLOT_W+LEVEL_W +: FLAGS_W];
    assign in_slot_ext = CMP_W'(in_slot);
    assign in_lvl_sat  = (in_level > LEVEL_W'(LEVEL_CAP)) ? LEVEL_CAP : in_level[VAL_W-1:0];
    assign in_fire     = s_axis_tvalid && s_axis_tready;

    // Configuration register
    logic active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (cfg_we) begin
            active_reg <= cfg_wdata;
        end
    end

    // Clearing sweep
    logic              clr_busy;
    logic [ADDR_W-1:0] clr_addr;

    ptdt_clr #(
        .DEPTH (THREAD_SLOTS)
    ) u_clr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (clr_busy),
        .addr    (clr_addr)
    );

    // Update stage registers
    logic               s1_valid_reg;
    logic               s1_mode_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic               s1_in_table_reg;
    logic [VAL_W-1:0]   s1_lvl_reg;
    logic [FLAGS_W-1:0] s1_flags_reg;

    // Bypass register: last word written by the update stage
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    duty_word_t         fwd_word_reg;

    // Table memory
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    duty_word_t cur_word;
    duty_word_t new_word;
    upd_res_t   upd;
    logic       s1_has_result;
    logic       s1_advance;

    ptdt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (THREAD_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (in_slot_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Select the freshest copy of the entry
    assign cur_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
                      ? fwd_word_reg : duty_word_t'(ram_rdata);

    ptdt_update u_update (
        .cur_word (cur_word),
        .mode     (s1_mode_reg),
        .lvl_sat  (s1_lvl_reg),
        .active   (active_reg),
        .in_table (s1_in_table_reg),
        .new_word (new_word),
        .res      (upd)
    );

    // Hold the update stage while its result cannot be placed
    assign s1_has_result = (s1_mode_reg == MODE_ENQ);
    assign s1_advance    = !s1_has_result || !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !clr_busy && (!s1_valid_reg || s1_advance);

    // Write port: sweep during clearing, else the update write-back
    always_comb begin
        if (clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_valid_reg && s1_advance && upd.we;
            ram_waddr = s1_addr_reg;
            ram_wdata = new_word;
        end
    end

    // Update stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Update stage payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_mode_reg     <= s_axis_tuser;
            s1_slot_reg     <= in_slot;
            s1_addr_reg     <= in_slot_ext[ADDR_W-1:0];
            s1_in_table_reg <= (in_slot_ext < SLOTS_LIM);
            s1_lvl_reg      <= in_lvl_sat;
            s1_flags_reg    <= in_flags;
        end
    end

    // Track the last write-back; drop it while the sweep runs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (clr_busy) begin
            fwd_valid_reg <= 1'b0;
        end else if (ram_we) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            fwd_addr_reg <= ram_waddr;
            fwd_word_reg <= new_word;
        end
    end

    // Output register
    logic load_out;

    assign load_out = s1_valid_reg && s1_advance && s1_has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tvalid <= 1'b0;
        end else if (load_out) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_axis_tuser <= upd.target;
            m_axis_tdata <= M_DATA_W'({s1_flags_reg, s1_slot_reg});
        end
    end

endmodule

`default_nettype wire

// ===== src/ptdt_chk.sv =====
// ----------------------------------------------------------------------------
// ptdt_chk
// Port-level checker for the per-thread duty throttle router, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdt_chk
    import ptdt_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                cfg_we,
    input wire logic                cfg_wdata,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [S_DATA_W-1:0] s_axis_tdata,
    input wire logic                s_axis_tuser,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata,
    input wire logic                m_axis_tuser
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // The table sweep blocks requests right after reset
    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("request ready during table clearing");

    // A fresh result comes from an enqueue transfer of the same slot
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |->
            ($past(s_axis_tvalid && s_axis_tready, 2)
             && ($past(s_axis_tuser, 2) == MODE_ENQ)
             && (m_axis_tdata[SLOT_W-1:0] == $past(s_axis_tdata[SLOT_W-1:0], 2))))
        else $error("result without matching enqueue transfer");

endmodule

bind per_thread_duty_throttle_router ptdt_chk u_ptdt_chk (.*);

`default_nettype wire
